/* hdl/swag_pkg.sv */
// Shared constants of the swirl warp address generator.
package swag_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_WIDTH      = 3'd0;
  localparam logic [2:0] CFG_HEIGHT     = 3'd1;
  localparam logic [2:0] CFG_X_CENTER   = 3'd2;
  localparam logic [2:0] CFG_Y_CENTER   = 3'd3;
  localparam logic [2:0] CFG_SPEED      = 3'd4;
  localparam logic [2:0] CFG_RANDOMNESS = 3'd5;
  localparam logic [2:0] CFG_SLOW_MODE  = 3'd6;
  localparam logic [2:0] CFG_REVERSE    = 3'd7;

  // Reset values of the configuration registers
  localparam logic [10:0] RST_WIDTH      = 11'd320;
  localparam logic [10:0] RST_HEIGHT     = 11'd200;
  localparam logic [9:0]  RST_X_CENTER   = 10'd106;
  localparam logic [9:0]  RST_Y_CENTER   = 10'd90;
  localparam logic [8:0]  RST_SPEED      = 9'd100;
  localparam logic [6:0]  RST_RANDOMNESS = 7'd70;
  localparam logic [1:0]  RST_SLOW_MODE  = 2'd2;
  localparam logic        RST_REVERSE    = 1'b0;

  // Arithmetic constants
  localparam logic [8:0]  PCT_BASE   = 9'd100;
  localparam logic [7:0]  RECIP3     = 8'd171;      // floor(x/3) = x*171 >> 9, x < 128
  localparam logic [10:0] RECIP100   = 11'd1310;    // floor(2^17/100), off by at most one
  localparam logic [6:0]  DIV100     = 7'd100;
  localparam logic [11:0] SLOW_GAIN  = 12'd2500;
  localparam logic [20:0] RECIP700   = 21'd1533916; // floor(2^30/700), off by at most one
  localparam logic [9:0]  DIV700     = 10'd700;

  // Pipelined divider depths (one quotient bit per stage)
  localparam int unsigned SLOW_QB = 11;  // slow-mode quotient stays below 2048
  localparam int unsigned WRAP_QB = 12;  // wrapped coordinate magnitude stays below 4096

endpackage

/* hdl/swag_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module swag_div #(
  parameter int unsigned NW = 22,  // numerator width
  parameter int unsigned DW = 21,  // denominator width
  parameter int unsigned QB = 11   // quotient bits, numerator < den * 2^QB
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = DW + QB;

  logic [CW-1:0] rem_in [QB];
  logic [DW-1:0] den_in [QB];
  logic [QB-1:0] quo_in [QB];
  logic [CW-1:0] rem_q  [QB];
  logic [DW-1:0] den_q  [QB];
  logic [QB-1:0] quo_q  [QB];

  assign rem_in[0] = CW'(num_i);
  assign den_in[0] = den_i;
  assign quo_in[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [CW-1:0] dsh;
    if (k > 0) begin : g_link
      assign rem_in[k] = rem_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign quo_in[k] = quo_q[k-1];
    end
    assign dsh = CW'(den_in[k]) << (QB - 1 - k);
    always_ff @(posedge clk_i) begin
      den_q[k] <= den_in[k];
      if (rem_in[k] >= dsh) begin
        rem_q[k] <= rem_in[k] - dsh;
        quo_q[k] <= quo_in[k] | (QB'(1) << (QB - 1 - k));
      end else begin
        rem_q[k] <= rem_in[k];
        quo_q[k] <= quo_in[k];
      end
    end
  end

  assign quo_o = quo_q[QB-1];
  assign rem_o = rem_q[QB-1][DW-1:0];

endmodule

/* hdl/spiral_warp_address_generator.sv */
// Top level of the swirl warp address generator: config, pipeline, address output.
//
//  Channel   Signals                                      Direction  Taken when
//  request   start_i, busy_o, pixel_x_i, pixel_y_i,       in         start_i && !busy_o
//            random_draw_i
//  result    done_o, source_address_o                     out        done_o (one cycle)
//  config    cfg_we_i, cfg_idx_i, cfg_data_i              in         cfg_we_i
//
// One request enters every cycle; busy_o stays low. The pipeline holds
// 3 front stages, 11 stages of the slow-mode divider, 5 stages of scaling and
// reciprocal division by 700, 12 stages of the wrap divider and 2 final stages.
// The receiver cannot stall, so the pipeline only advances and valid bits travel along.
// Reset (rst_ni low) loads the register defaults and drops every request in flight.
module spiral_warp_address_generator #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [9:0]  pixel_x_i,
  input  logic [9:0]  pixel_y_i,
  input  logic [6:0]  random_draw_i,
  output logic        done_o,
  output logic [19:0] source_address_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  localparam int unsigned WW   = $clog2(MAX_DIM + 1);   // clamped dimension width
  localparam int unsigned CFW  = (WW > 11) ? WW : 11;   // width for the clamp compare
  localparam int unsigned AW   = (2 * WW + 1 > 20) ? 2 * WW + 1 : 20;
  localparam int unsigned DIVL = swag_pkg::SLOW_QB;
  localparam int unsigned MODL = swag_pkg::WRAP_QB;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] width_q, height_q;
  logic [9:0]  x_center_q, y_center_q;
  logic [8:0]  speed_q;
  logic [6:0]  randomness_q;
  logic [1:0]  slow_mode_q;
  logic        reverse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= swag_pkg::RST_WIDTH;
      height_q     <= swag_pkg::RST_HEIGHT;
      x_center_q   <= swag_pkg::RST_X_CENTER;
      y_center_q   <= swag_pkg::RST_Y_CENTER;
      speed_q      <= swag_pkg::RST_SPEED;
      randomness_q <= swag_pkg::RST_RANDOMNESS;
      slow_mode_q  <= swag_pkg::RST_SLOW_MODE;
      reverse_q    <= swag_pkg::RST_REVERSE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swag_pkg::CFG_WIDTH:      width_q      <= cfg_data_i;
        swag_pkg::CFG_HEIGHT:     height_q     <= cfg_data_i;
        swag_pkg::CFG_X_CENTER:   x_center_q   <= cfg_data_i[9:0];
        swag_pkg::CFG_Y_CENTER:   y_center_q   <= cfg_data_i[9:0];
        swag_pkg::CFG_SPEED:      speed_q      <= cfg_data_i[8:0];
        swag_pkg::CFG_RANDOMNESS: randomness_q <= cfg_data_i[6:0];
        swag_pkg::CFG_SLOW_MODE:  slow_mode_q  <= cfg_data_i[1:0];
        swag_pkg::CFG_REVERSE:    reverse_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the wrap moduli to 1..MAX_DIM; the user must keep config static while requests run (left to the user).
  logic [WW-1:0] w_clamp, h_clamp;

  always_comb begin
    if (width_q == '0) begin
      w_clamp = WW'(1);
    end else if (CFW'(width_q) > CFW'(MAX_DIM)) begin
      w_clamp = WW'(MAX_DIM);
    end else begin
      w_clamp = WW'(width_q);
    end
    if (height_q == '0) begin
      h_clamp = WW'(1);
    end else if (CFW'(height_q) > CFW'(MAX_DIM)) begin
      h_clamp = WW'(MAX_DIM);
    end else begin
      h_clamp = WW'(height_q);
    end
  end

  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage A: center offsets, speed numerator speed * (100 + draw - r/3)
  // ---------------------------------------------------------------------------
  logic               a_vld_q;
  logic [9:0]         a_px_q, a_py_q;
  logic signed [10:0] a_dx_q, a_dy_q;
  logic [16:0]        a_spn_q;
  logic [6:0]         a_draw;
  logic [14:0]        a_r3p;
  logic [8:0]         a_pct;

  always_comb begin
    a_draw = (random_draw_i > randomness_q) ? randomness_q : random_draw_i;
    a_r3p  = 15'(randomness_q) * 15'(swag_pkg::RECIP3);
    a_pct  = swag_pkg::PCT_BASE + 9'(a_draw) - 9'(a_r3p[14:9]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_px_q  <= pixel_x_i;
    a_py_q  <= pixel_y_i;
    a_dx_q  <= $signed({1'b0, pixel_x_i}) - $signed({1'b0, x_center_q});
    a_dy_q  <= $signed({1'b0, pixel_y_i}) - $signed({1'b0, y_center_q});
    a_spn_q <= 17'(speed_q) * 17'(a_pct[7:0]);
  end

  // ---------------------------------------------------------------------------
  // Stage B: squares, slow-mode numerators, first guess of speed / 100
  // ---------------------------------------------------------------------------
  logic               b_vld_q;
  logic [9:0]         b_px_q, b_py_q;
  logic signed [10:0] b_dx_q, b_dy_q;
  logic [19:0]        b_dx2_q, b_dy2_q;
  logic [21:0]        b_nx_q, b_ny_q;
  logic [16:0]        b_spn_q;
  logic [10:0]        b_spq_q;
  logic [9:0]         b_adx, b_ady;
  logic [27:0]        b_spp;

  always_comb begin
    b_adx = a_dx_q[10] ? 10'(-a_dx_q) : a_dx_q[9:0];
    b_ady = a_dy_q[10] ? 10'(-a_dy_q) : a_dy_q[9:0];
    b_spp = 28'(a_spn_q) * 28'(swag_pkg::RECIP100);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_px_q  <= a_px_q;
    b_py_q  <= a_py_q;
    b_dx_q  <= a_dx_q;
    b_dy_q  <= a_dy_q;
    b_dx2_q <= 20'(b_adx) * 20'(b_adx);
    b_dy2_q <= 20'(b_ady) * 20'(b_ady);
    b_nx_q  <= 22'(b_adx) * 22'(swag_pkg::SLOW_GAIN);
    b_ny_q  <= 22'(b_ady) * 22'(swag_pkg::SLOW_GAIN);
    b_spn_q <= a_spn_q;
    b_spq_q <= b_spp[27:17];
  end

  // ---------------------------------------------------------------------------
  // Stage C: squared distance plus one, final signed speed
  // ---------------------------------------------------------------------------
  logic               c_vld_q;
  logic [9:0]         c_px_q, c_py_q;
  logic signed [10:0] c_dx_q, c_dy_q;
  logic [20:0]        c_d2_q;
  logic [21:0]        c_nx_q, c_ny_q;
  logic signed [11:0] c_sp_q;
  logic [17:0]        c_sprem;
  logic [10:0]        c_spm;

  always_comb begin
    // correct the reciprocal guess by at most one
    c_sprem = 18'(b_spn_q) - 18'(b_spq_q) * 18'(swag_pkg::DIV100);
    if (randomness_q == '0) begin
      c_spm = 11'(speed_q);
    end else if (c_sprem >= 18'(swag_pkg::DIV100)) begin
      c_spm = b_spq_q + 11'd1;
    end else begin
      c_spm = b_spq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_px_q <= b_px_q;
    c_py_q <= b_py_q;
    c_dx_q <= b_dx_q;
    c_dy_q <= b_dy_q;
    c_d2_q <= 21'(b_dx2_q) + 21'(b_dy2_q) + 21'd1;
    c_nx_q <= b_nx_q;
    c_ny_q <= b_ny_q;
    c_sp_q <= reverse_q ? -$signed({1'b0, c_spm}) : $signed({1'b0, c_spm});
  end

  // ---------------------------------------------------------------------------
  // Slow-mode dividers: |d| * 2500 / d2, with side data held in a delay line
  // ---------------------------------------------------------------------------
  logic [10:0] qx, qy;

  swag_div #(.NW(22), .DW(21), .QB(DIVL)) u_div_x (
    .clk_i (clk_i),
    .num_i (c_nx_q),
    .den_i (c_d2_q),
    .quo_o (qx),
    .rem_o ()
  );

  swag_div #(.NW(22), .DW(21), .QB(DIVL)) u_div_y (
    .clk_i (clk_i),
    .num_i (c_ny_q),
    .den_i (c_d2_q),
    .quo_o (qy),
    .rem_o ()
  );

  logic               dl_vld_q [DIVL];
  logic [9:0]         dl_px_q  [DIVL];
  logic [9:0]         dl_py_q  [DIVL];
  logic signed [10:0] dl_dx_q  [DIVL];
  logic signed [10:0] dl_dy_q  [DIVL];
  logic signed [11:0] dl_sp_q  [DIVL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIVL; k++) dl_vld_q[k] <= 1'b0;
    end else begin
      dl_vld_q[0] <= c_vld_q;
      for (int k = 1; k < DIVL; k++) dl_vld_q[k] <= dl_vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dl_px_q[0] <= c_px_q;
    dl_py_q[0] <= c_py_q;
    dl_dx_q[0] <= c_dx_q;
    dl_dy_q[0] <= c_dy_q;
    dl_sp_q[0] <= c_sp_q;
    for (int k = 1; k < DIVL; k++) begin
      dl_px_q[k] <= dl_px_q[k-1];
      dl_py_q[k] <= dl_py_q[k-1];
      dl_dx_q[k] <= dl_dx_q[k-1];
      dl_dy_q[k] <= dl_dy_q[k-1];
      dl_sp_q[k] <= dl_sp_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: pick slowed or raw offsets
  // ---------------------------------------------------------------------------
  logic               e_vld_q;
  logic [9:0]         e_px_q, e_py_q;
  logic signed [11:0] e_dx_q, e_dy_q, e_sp_q;
  logic signed [10:0] e_rdx, e_rdy;

  assign e_rdx = dl_dx_q[DIVL-1];
  assign e_rdy = dl_dy_q[DIVL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= dl_vld_q[DIVL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    e_px_q <= dl_px_q[DIVL-1];
    e_py_q <= dl_py_q[DIVL-1];
    e_sp_q <= dl_sp_q[DIVL-1];
    if (slow_mode_q[1]) begin
      e_dx_q <= e_rdx[10] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    end else begin
      e_dx_q <= 12'(e_rdx);
    end
    if (slow_mode_q[0]) begin
      e_dy_q <= e_rdy[10] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end else begin
      e_dy_q <= 12'(e_rdy);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: magnitudes of dy * sp and dx * sp, signs kept apart
  // ---------------------------------------------------------------------------
  logic        f_vld_q;
  logic [9:0]  f_px_q, f_py_q;
  logic [21:0] f_mc_q, f_mr_q;
  logic        f_sc_q, f_sr_q;
  logic [10:0] f_adx, f_ady, f_asp;

  always_comb begin
    f_adx = e_dx_q[11] ? 11'(-e_dx_q) : e_dx_q[10:0];
    f_ady = e_dy_q[11] ? 11'(-e_dy_q) : e_dy_q[10:0];
    f_asp = e_sp_q[11] ? 11'(-e_sp_q) : e_sp_q[10:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_px_q <= e_px_q;
    f_py_q <= e_py_q;
    f_mc_q <= 22'(f_ady) * 22'(f_asp);
    f_mr_q <= 22'(f_adx) * 22'(f_asp);
    f_sc_q <= e_dy_q[11] ^ e_sp_q[11];
    f_sr_q <= e_dx_q[11] ^ e_sp_q[11];
  end

  // ---------------------------------------------------------------------------
  // Stage G: reciprocal guess of magnitude / 700
  // ---------------------------------------------------------------------------
  logic        g_vld_q;
  logic [9:0]  g_px_q, g_py_q;
  logic [21:0] g_mc_q, g_mr_q;
  logic        g_sc_q, g_sr_q;
  logic [11:0] g_qc_q, g_qr_q;
  logic [42:0] g_pc, g_pr;

  always_comb begin
    g_pc = 43'(f_mc_q) * 43'(swag_pkg::RECIP700);
    g_pr = 43'(f_mr_q) * 43'(swag_pkg::RECIP700);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_px_q <= f_px_q;
    g_py_q <= f_py_q;
    g_mc_q <= f_mc_q;
    g_mr_q <= f_mr_q;
    g_sc_q <= f_sc_q;
    g_sr_q <= f_sr_q;
    g_qc_q <= g_pc[41:30];
    g_qr_q <= g_pr[41:30];
  end

  // ---------------------------------------------------------------------------
  // Stage H: correct the guess by at most one
  // ---------------------------------------------------------------------------
  logic        h_vld_q;
  logic [9:0]  h_px_q, h_py_q;
  logic        h_sc_q, h_sr_q;
  logic [11:0] h_qc_q, h_qr_q;
  logic [21:0] h_rc, h_rr;

  always_comb begin
    h_rc = g_mc_q - 22'(g_qc_q) * 22'(swag_pkg::DIV700);
    h_rr = g_mr_q - 22'(g_qr_q) * 22'(swag_pkg::DIV700);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_px_q <= g_px_q;
    h_py_q <= g_py_q;
    h_sc_q <= g_sc_q;
    h_sr_q <= g_sr_q;
    h_qc_q <= (h_rc >= 22'(swag_pkg::DIV700)) ? g_qc_q + 12'd1 : g_qc_q;
    h_qr_q <= (h_rr >= 22'(swag_pkg::DIV700)) ? g_qr_q + 12'd1 : g_qr_q;
  end

  // ---------------------------------------------------------------------------
  // Stage I: unwrapped column and row as magnitude and sign
  // ---------------------------------------------------------------------------
  logic               i_vld_q;
  logic [11:0]        i_cm_q, i_rm_q;
  logic               i_cn_q, i_rn_q;
  logic signed [12:0] i_col, i_row;

  always_comb begin
    // col = px + dy*sp/700, row = py - dx*sp/700
    i_col = $signed({3'b0, h_px_q}) +
            (h_sc_q ? -$signed({1'b0, h_qc_q}) : $signed({1'b0, h_qc_q}));
    i_row = $signed({3'b0, h_py_q}) +
            (h_sr_q ? $signed({1'b0, h_qr_q}) : -$signed({1'b0, h_qr_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_vld_q <= 1'b0;
    end else begin
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i_cn_q <= i_col[12];
    i_rn_q <= i_row[12];
    i_cm_q <= i_col[12] ? 12'(-i_col) : i_col[11:0];
    i_rm_q <= i_row[12] ? 12'(-i_row) : i_row[11:0];
  end

  // ---------------------------------------------------------------------------
  // Wrap dividers: |col| mod width, |row| mod height
  // ---------------------------------------------------------------------------
  logic [WW-1:0] rc, rr;

  swag_div #(.NW(12), .DW(WW), .QB(MODL)) u_mod_col (
    .clk_i (clk_i),
    .num_i (i_cm_q),
    .den_i (w_clamp),
    .quo_o (),
    .rem_o (rc)
  );

  swag_div #(.NW(12), .DW(WW), .QB(MODL)) u_mod_row (
    .clk_i (clk_i),
    .num_i (i_rm_q),
    .den_i (h_clamp),
    .quo_o (),
    .rem_o (rr)
  );

  logic ml_vld_q [MODL];
  logic ml_cn_q  [MODL];
  logic ml_rn_q  [MODL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MODL; k++) ml_vld_q[k] <= 1'b0;
    end else begin
      ml_vld_q[0] <= i_vld_q;
      for (int k = 1; k < MODL; k++) ml_vld_q[k] <= ml_vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ml_cn_q[0] <= i_cn_q;
    ml_rn_q[0] <= i_rn_q;
    for (int k = 1; k < MODL; k++) begin
      ml_cn_q[k] <= ml_cn_q[k-1];
      ml_rn_q[k] <= ml_rn_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage J: floored modulo for negative values
  // ---------------------------------------------------------------------------
  logic          j_vld_q;
  logic [WW-1:0] j_col_q, j_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_vld_q <= 1'b0;
    end else begin
      j_vld_q <= ml_vld_q[MODL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    j_col_q <= (ml_cn_q[MODL-1] && rc != '0) ? w_clamp - rc : rc;
    j_row_q <= (ml_rn_q[MODL-1] && rr != '0) ? h_clamp - rr : rr;
  end

  // ---------------------------------------------------------------------------
  // Stage K: linear address row * width + column, masked to 20 bits
  // ---------------------------------------------------------------------------
  logic          k_vld_q;
  logic [19:0]   k_addr_q;
  logic [AW-1:0] k_addr;

  assign k_addr = AW'(j_row_q) * AW'(w_clamp) + AW'(j_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_vld_q <= 1'b0;
    end else begin
      k_vld_q <= j_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k_addr_q <= k_addr[19:0];
  end

  assign done_o           = k_vld_q;
  assign source_address_o = k_addr_q;

endmodule
